// ===== src/int_to_decimal_ascii_macros.svh =====
// ----------------------------------------------------------------------------
// int_to_decimal_ascii assertion macros
// Property wrappers used by the asserting file of the block.
// ----------------------------------------------------------------------------
`ifndef INT_TO_DECIMAL_ASCII_MACROS_SVH
`define INT_TO_DECIMAL_ASCII_MACROS_SVH

// same-cycle implication
`define I2DA_ASSERT_SAME(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("i2da assertion failed");

// next-cycle implication
`define I2DA_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("i2da assertion failed");

`endif

// ===== src/i2da_pkg.sv =====
// ----------------------------------------------------------------------------
// i2da_pkg
// Widths, character codes and decimal weight table for int_to_decimal_ascii.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package i2da_pkg;

   localparam int MAG_W    = 32;
   localparam int WEIGHT_W = 33;
   localparam int CHAR_W   = 8;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
   localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

   localparam logic [MAG_W-1:0] MOST_NEG = 32'h8000_0000;

   localparam logic [3:0] TOP_POS   = 4'd9;
   localparam logic [1:0] LAST_STEP = 2'd3;

   // weight of digit bit (8,4,2,1 for step 0..3) at decimal position pos
   function automatic logic [WEIGHT_W-1:0] digit_weight(logic [3:0] pos, logic [1:0] step);
      logic [WEIGHT_W-1:0] p10;
      case (pos)
         4'd0:    p10 = 33'd1;
         4'd1:    p10 = 33'd10;
         4'd2:    p10 = 33'd100;
         4'd3:    p10 = 33'd1000;
         4'd4:    p10 = 33'd10000;
         4'd5:    p10 = 33'd100000;
         4'd6:    p10 = 33'd1000000;
         4'd7:    p10 = 33'd10000000;
         4'd8:    p10 = 33'd100000000;
         4'd9:    p10 = 33'd1000000000;
         default: p10 = 33'd0;
      endcase
      return p10 << (LAST_STEP - step);
   endfunction

endpackage

`default_nettype wire

// ===== src/int_to_decimal_ascii.sv =====
// ----------------------------------------------------------------------------
// int_to_decimal_ascii
// 32-bit word to decimal ASCII, most significant character first.
// ----------------------------------------------------------------------------
// Timing: the '-' (if any) appears in the cycle after accept, and the digits
// follow place by place; one compare-subtract per cycle, 4 per decimal place.
// busy is high while the places are worked; a new number is taken only when busy is low.
// Results are strobed for one cycle each; the receiver cannot stall.
// Synchronous active-high reset returns to idle with no result pending.
`timescale 1ns / 1ps
`default_nettype none

`include "int_to_decimal_ascii_macros.svh"

module int_to_decimal_ascii (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [i2da_pkg::MAG_W-1:0]  req_value_bits,
   input  wire logic                        req_signed_mode,
   input  wire logic                        req_omit_sign,
   output logic                             rsp_strobe,
   output logic [i2da_pkg::CHAR_W-1:0]      rsp_char_code,
   output logic                             rsp_last_char
);
   import i2da_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_DIGIT = 2'b10
   } state_type;

   state_type          state_ff, state_in;
   logic [MAG_W-1:0]   mag_ff, mag_in;
   logic [3:0]         pos_ff, pos_in;
   logic [1:0]         step_ff, step_in;
   logic [3:0]         digit_ff, digit_in;
   logic               started_ff, started_in;
   logic               strobe_ff, strobe_in;
   logic [CHAR_W-1:0]  char_ff, char_in;
   logic               last_ff, last_in;

   logic [WEIGHT_W-1:0] weight;
   logic                ge;
   logic [MAG_W-1:0]    diff;
   logic [3:0]          digit_next;
   logic                neg;
   logic                emit;
   logic                char_is_digit;

   assign weight = digit_weight(pos_ff, step_ff);

   i2da_csub u_csub (
      .mag    (mag_ff),
      .weight (weight),
      .ge     (ge),
      .diff   (diff)
   );

   assign digit_next = digit_ff | (ge ? (4'b1000 >> step_ff) : 4'b0000);
   assign neg        = req_signed_mode && req_value_bits[MAG_W-1];
   assign emit       = (digit_next != 4'd0) || started_ff || (pos_ff == 4'd0);

   always_comb begin
      state_in   = state_ff;
      mag_in     = mag_ff;
      pos_in     = pos_ff;
      step_in    = step_ff;
      digit_in   = digit_ff;
      started_in = started_ff;
      strobe_in  = 1'b0;
      char_in    = char_ff;
      last_in    = last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in   = ST_DIGIT;
               mag_in     = neg ? (MAG_W'(0) - req_value_bits) : req_value_bits;
               pos_in     = TOP_POS;
               step_in    = 2'd0;
               digit_in   = 4'd0;
               started_in = 1'b0;
               if (neg && !(req_value_bits == MOST_NEG && req_omit_sign)) begin
                  strobe_in = 1'b1;
                  char_in   = CHAR_MINUS;
                  last_in   = 1'b0;
               end
            end
         end
         ST_DIGIT: begin
            mag_in = ge ? diff : mag_ff;
            if (step_ff == LAST_STEP) begin
               if (emit) begin
                  strobe_in  = 1'b1;
                  char_in    = CHAR_ZERO + {4'd0, digit_next};
                  last_in    = (pos_ff == 4'd0);
                  started_in = 1'b1;
               end
               digit_in = 4'd0;
               step_in  = 2'd0;
               if (pos_ff == 4'd0) begin
                  state_in = ST_IDLE;
               end else begin
                  pos_in = pos_ff - 4'd1;
               end
            end else begin
               digit_in = digit_next;
               step_in  = step_ff + 2'd1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         strobe_ff  <= 1'b0;
         started_ff <= 1'b0;
         pos_ff     <= 4'd0;
         step_ff    <= 2'd0;
         digit_ff   <= 4'd0;
      end else begin
         state_ff   <= state_in;
         strobe_ff  <= strobe_in;
         started_ff <= started_in;
         pos_ff     <= pos_in;
         step_ff    <= step_in;
         digit_ff   <= digit_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff  <= mag_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_strobe    = strobe_ff;
   assign rsp_char_code = char_ff;
   assign rsp_last_char = last_ff;

   assign char_is_digit = (rsp_char_code >= CHAR_ZERO) && (rsp_char_code <= CHAR_NINE);

   `I2DA_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `I2DA_ASSERT_SAME(a_idle_last, clock, reset, rsp_strobe && !busy, rsp_last_char)
   `I2DA_ASSERT_SAME(a_last_digit, clock, reset, rsp_strobe && rsp_last_char, char_is_digit)
   `I2DA_ASSERT_SAME(a_char_range, clock, reset, rsp_strobe, rsp_char_code == CHAR_MINUS || char_is_digit)

endmodule

`default_nettype wire

// ===== src/i2da_csub.sv =====
// ----------------------------------------------------------------------------
// i2da_csub
// Compare-subtract unit: tests magnitude against a weight and
// returns the reduced magnitude.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module i2da_csub (
   input  wire logic [i2da_pkg::MAG_W-1:0]    mag,
   input  wire logic [i2da_pkg::WEIGHT_W-1:0] weight,
   output logic                               ge,
   output logic [i2da_pkg::MAG_W-1:0]         diff
);
   import i2da_pkg::*;

   assign ge   = {{(WEIGHT_W-MAG_W){1'b0}}, mag} >= weight;
   assign diff = mag - weight[MAG_W-1:0];

endmodule

`default_nettype wire

// ===== tb/int_to_decimal_ascii_test.sv =====
// ----------------------------------------------------------------------------
// int_to_decimal_ascii_test
// Sends 32-bit words in signed and unsigned mode, with and without the
// omit-sign flag, and checks every strobed character and its last-character
// mark against a decimal rendering worked out in the bench.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module int_to_decimal_ascii_test;

   import i2da_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int RANDOM_ITEMS = 290;
   localparam int DRAIN_CYCLES = 50;

   typedef struct packed {
      logic [CHAR_W-1:0] code;
      logic              last;
   } ascii_char_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic [MAG_W-1:0]  req_value_bits = '0;
   logic              req_signed_mode = 1'b0;
   logic              req_omit_sign = 1'b0;
   wire               busy;
   wire               rsp_strobe;
   wire [CHAR_W-1:0]  rsp_char_code;
   wire               rsp_last_char;

   ascii_char_type expected_chars[$];
   int error_count = 0;
   int numbers_sent = 0;
   int chars_checked = 0;
   int minus_checked = 0;
   int cycle_count = 0;
   int burst_left = 0;

   int_to_decimal_ascii u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_value_bits  (req_value_bits),
      .req_signed_mode (req_signed_mode),
      .req_omit_sign   (req_omit_sign),
      .rsp_strobe      (rsp_strobe),
      .rsp_char_code   (rsp_char_code),
      .rsp_last_char   (rsp_last_char)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d characters outstanding",
                  cycle_count, expected_chars.size());
         $display("int_to_decimal_ascii_test: errors");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   function automatic void push_char(input logic [CHAR_W-1:0] code, input logic last);
      ascii_char_type c;
      c.code = code;
      c.last = last;
      expected_chars.push_back(c);
   endfunction

   // decimal rendering of one word, most significant character first
   function automatic void predict_chars(input logic [MAG_W-1:0] value,
                                         input logic sgn, input logic omit);
      logic [MAG_W-1:0]  mag;
      logic [CHAR_W-1:0] rev [10];
      int n;
      mag = value;
      n = 0;
      if (sgn && value[MAG_W-1]) begin
         mag = -value;
         if (!(value == MOST_NEG && omit))
            push_char(CHAR_MINUS, 1'b0);
      end
      do begin
         rev[n] = CHAR_ZERO + CHAR_W'(mag % 10);
         n++;
         mag = mag / 10;
      end while (mag != 0);
      for (int i = n - 1; i >= 0; i--)
         push_char(rev[i], i == 0);
   endfunction

   always @(posedge clock) begin
      ascii_char_type want;
      if (!reset && rsp_strobe) begin
         if (expected_chars.size() == 0) begin
            report_mismatch($sformatf("unexpected character %0d last=%0b",
                                      rsp_char_code, rsp_last_char));
         end else begin
            want = expected_chars.pop_front();
            chars_checked++;
            if (want.code == CHAR_MINUS)
               minus_checked++;
            if (rsp_char_code !== want.code)
               report_mismatch($sformatf("char_code %0d, expected %0d",
                                         rsp_char_code, want.code));
            if (rsp_last_char !== want.last)
               report_mismatch($sformatf("last_char %0b, expected %0b (char %0d)",
                                         rsp_last_char, want.last, want.code));
         end
      end
   end

   // one transaction: random idle gap, then hold start until busy is low
   task automatic send_number(input logic [MAG_W-1:0] value, input logic sgn,
                              input logic omit);
      int gap;
      if (burst_left > 0) begin
         burst_left--;
         gap = 0;
      end else begin
         gap = $urandom_range(0, 15);
         if ($urandom_range(0, 7) == 0)
            burst_left = $urandom_range(4, 16);
      end
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_value_bits <= value;
      req_signed_mode <= sgn;
      req_omit_sign <= omit;
      do @(posedge clock); while (busy);
      predict_chars(value, sgn, omit);
      numbers_sent++;
   endtask

   task automatic test_special_values;
      send_number(32'd0, 1'b0, 1'b0);
      send_number(32'd0, 1'b1, 1'b1);
      send_number(32'hFFFF_FFFF, 1'b0, 1'b0);
      send_number(32'hFFFF_FFFF, 1'b0, 1'b1);
      send_number(32'hFFFF_FFFF, 1'b1, 1'b0);
      send_number(32'hFFFF_FFFF, 1'b1, 1'b1);
      send_number(MOST_NEG, 1'b1, 1'b0);
      send_number(MOST_NEG, 1'b1, 1'b1);
      send_number(MOST_NEG, 1'b0, 1'b1);
      send_number(MOST_NEG, 1'b0, 1'b0);
      send_number(32'h7FFF_FFFF, 1'b1, 1'b1);
      send_number(32'h8000_0001, 1'b1, 1'b1);
      send_number(32'h8000_0001, 1'b1, 1'b0);
      send_number(32'd9, 1'b1, 1'b0);
      send_number(32'd10, 1'b0, 1'b1);
      send_number(32'd999_999_999, 1'b0, 1'b0);
      send_number(32'd1_000_000_000, 1'b1, 1'b0);
      send_number(-32'sd10, 1'b1, 1'b1);
      send_number(32'hAAAA_AAAA, 1'b0, 1'b0);
      send_number(32'h5555_5555, 1'b1, 1'b1);
   endtask

   task automatic test_digit_counts;
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned span;
      for (int d = 0; d < 10; d++) begin
         lo = 1;
         repeat (d) lo = lo * 10;
         hi = lo * 10 - 1;
         if (hi > 64'hFFFF_FFFF)
            hi = 64'hFFFF_FFFF;
         span = hi - lo + 1;
         send_number(MAG_W'(lo + {$urandom, $urandom} % span), 1'b0, 1'($urandom));
         send_number(-MAG_W'(lo + {$urandom, $urandom} % span), 1'b1, 1'($urandom));
      end
   endtask

   task automatic test_random_words;
      logic [MAG_W-1:0] value;
      logic sgn;
      int kind;
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         kind = $urandom_range(0, 9);
         sgn = 1'($urandom);
         case (kind)
            0, 1, 2, 3: value = $urandom;
            4, 5, 6:    value = $urandom >> $urandom_range(0, 31);
            7, 8: begin
               value = -($urandom >> $urandom_range(0, 31));
               sgn = 1'b1;
            end
            default: begin
               case ($urandom_range(0, 3))
                  0:       value = '0;
                  1:       value = MOST_NEG;
                  2:       value = 32'h7FFF_FFFF;
                  default: value = 32'hFFFF_FFFF;
               endcase
            end
         endcase
         send_number(value, sgn, 1'($urandom));
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_special_values();
      test_digit_counts();
      test_random_words();
      start <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("converted %0d words into %0d characters, %0d of them minus signs",
               numbers_sent, chars_checked, minus_checked);
      $display("mismatches: %0d", error_count);
      if (error_count == 0)
         $display("int_to_decimal_ascii_test: clean");
      else
         $display("int_to_decimal_ascii_test: errors");
      $finish;
   end

endmodule

// ===== int_to_decimal_ascii.f =====
+incdir+src
src/i2da_pkg.sv
src/i2da_csub.sv
src/int_to_decimal_ascii.sv
tb/int_to_decimal_ascii_test.sv
